// File: hw/rtl/crc8_framed_packet_receiver_core_assert.svh
// Assertion macros shared by the receiver RTL.
`ifndef CRC8_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CRC8FPR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define CRC8FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/crc8fpr_pkg.sv
// Package with the constants, types and functions of the framed packet receiver.
package crc8fpr_pkg;

  localparam int DATA_BYTES = 3;
  localparam int PHASE_W    = $clog2(DATA_BYTES + 2);
  localparam int PL_IDX_W   = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_MSB    = 8'h80;

  localparam logic [5:0] POS_OFFSET = 6'd25;
  // x / 10 equals (x * 205) >> 11 for every 8-bit x.
  localparam logic [7:0] DIV10_MUL  = 8'd205;
  localparam int         DIV10_SHR  = 11;

  localparam int         SCALE_W           = 10;
  localparam logic [9:0] ANGLE_SCALE_RESET = 10'd361;

  localparam logic [PHASE_W-1:0] PH_HUNT  = '0;
  localparam logic [PHASE_W-1:0] PH_CHECK = PHASE_W'(DATA_BYTES + 1);

  typedef logic [DATA_BYTES-1:0][7:0] payload_t;

  typedef struct packed {
    logic check_byte;  // the next item is the check byte
    logic crc_match;   // the offered byte equals the running CRC
  } frame_status_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [5:0] peer_pos(input logic [7:0] b);
    logic [15:0] prod;
    prod = 16'(b) * 16'(DIV10_MUL);
    return 6'(prod[15:DIV10_SHR]) + POS_OFFSET;
  endfunction

endpackage

// File: hw/rtl/crc8fpr_rx_if.sv
// Byte channel into the receiver.
interface crc8fpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/crc8fpr_peer_if.sv
// Result channel carrying decoded peer position and angle.
interface crc8fpr_peer_if;
  logic       valid;
  logic       ready;
  logic [5:0] peer_x;
  logic [5:0] peer_y;
  logic [9:0] peer_angle;

  modport source (output valid, output peer_x, output peer_y, output peer_angle, input ready);
  modport sink (input valid, input peer_x, input peer_y, input peer_angle, output ready);
endinterface

// File: hw/rtl/crc8fpr_deframer.sv
// Frame hunting, payload capture and running CRC of the receiver.
module crc8fpr_deframer
  import crc8fpr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output frame_status_t status,
  output payload_t      payload
);

  `include "crc8_framed_packet_receiver_core_assert.svh"

  logic [PHASE_W-1:0]  phase;
  logic [7:0]          crc;
  logic [PHASE_W-1:0]  phase_dec;
  logic [PL_IDX_W-1:0] pidx;
  logic                in_payload;

  assign phase_dec  = phase - PHASE_W'(1);
  assign pidx       = phase_dec[PL_IDX_W-1:0];
  assign in_payload = (phase != PH_HUNT) && (phase != PH_CHECK);

  assign status.check_byte = (phase == PH_CHECK);
  assign status.crc_match  = (rx_byte == crc);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      crc   <= CRC_INIT;
    end else if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == START_BYTE) begin
            phase <= PHASE_W'(1);
            crc   <= CRC_INIT;
          end
        end
        PH_CHECK: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= phase + PHASE_W'(1);
          crc   <= crc8_step(crc, rx_byte);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_payload) begin
      payload[pidx] <= rx_byte;
    end
  end

  `CRC8FPR_ASSERT_ALWAYS(a_phase_range, phase <= PH_CHECK, "frame phase beyond check byte")
  `CRC8FPR_ASSERT_NEXT(a_check_ends_frame, accept && status.check_byte, phase == PH_HUNT,
                       "frame did not end after its check byte")

endmodule

// File: hw/rtl/crc8_framed_packet_receiver_core.sv
// Top level of the CRC-8 framed packet receiver.
// Throughput: one byte item per cycle; only a check byte waits, and only while an
// earlier result sits untaken in the output register.
// Latency: a result is valid in the cycle after its check byte is accepted.
// Reset: hunting for a start byte, angle_scale back to 361, no result pending.
module crc8_framed_packet_receiver_core
  import crc8fpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  crc8fpr_rx_if.sink         rx,
  crc8fpr_peer_if.source     peer
);

  `include "crc8_framed_packet_receiver_core_assert.svh"

  frame_status_t      status;
  payload_t           payload;
  logic               rx_accept;
  logic               frame_ok;
  logic [SCALE_W-1:0] angle_scale;
  logic               out_valid;
  logic [5:0]         out_x;
  logic [5:0]         out_y;
  logic [9:0]         out_angle;
  logic [17:0]        angle_prod;

  // Bytes that cannot produce a result are taken even while the output is full.
  assign rx.ready  = !status.check_byte || !out_valid || peer.ready;
  assign rx_accept = rx.valid && rx.ready;
  assign frame_ok  = rx_accept && status.check_byte && status.crc_match;

  crc8fpr_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx_accept),
    .rx_byte (rx.rx_byte),
    .status  (status),
    .payload (payload)
  );

  assign angle_prod = 18'(payload[2]) * 18'(angle_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      angle_scale <= ANGLE_SCALE_RESET;
    end else begin
      if (cfg_wr_en) begin
        angle_scale <= cfg_wr_data;
      end
      if (frame_ok) begin
        out_valid <= 1'b1;
      end else if (peer.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ok) begin
      out_x     <= peer_pos(payload[0]);
      out_y     <= peer_pos(payload[1]);
      out_angle <= angle_prod[17:8];
    end
  end

  assign peer.valid      = out_valid;
  assign peer.peer_x     = out_x;
  assign peer.peer_y     = out_y;
  assign peer.peer_angle = out_angle;

  `CRC8FPR_ASSERT_NEXT(a_result_kept, out_valid && !peer.ready, out_valid,
                       "pending result dropped before it was taken")
  `CRC8FPR_ASSERT_NEXT(a_result_source, !frame_ok && !(out_valid && !peer.ready), !out_valid,
                       "result appeared without a matching check byte")

endmodule

// File: tb/sv/crc8fpr_tb_pkg.sv
// Shared testbench types and the CRC-8 step used for prediction and for building frames.
package crc8fpr_tb_pkg;

  typedef struct packed {
    logic [5:0] x;
    logic [5:0] y;
    logic [9:0] angle;
  } peer_fix_t;

  // One byte through the CRC, MSB first, polynomial 0x31, no reflection.
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ 8'h31;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: tb/sv/crc8fpr_checker.sv
// Checker that follows the byte stream, predicts peer results and compares them.
module crc8fpr_checker
  import crc8fpr_pkg::*;
  import crc8fpr_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  crc8fpr_rx_if              rx,
  crc8fpr_peer_if            peer,
  output int                 errors,
  output int                 outstanding,
  output int                 fixes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PHASE_W-1:0] phase;
  logic [7:0]         frame_buf [DATA_BYTES];
  logic [7:0]         crc_acc;
  logic [SCALE_W-1:0] scale;
  peer_fix_t          fixes_due [$];

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    peer_fix_t fix;
    if (phase == PH_HUNT) begin
      if (b == START_BYTE) begin
        crc_acc = CRC_INIT;
        phase = PHASE_W'(1);
      end
    end else if (phase != PH_CHECK) begin
      frame_buf[PL_IDX_W'(phase - 1'b1)] = b;
      crc_acc = crc8_next(crc_acc, b);
      phase = phase + 1'b1;
    end else begin
      // A bad check byte drops the frame silently.
      phase = PH_HUNT;
      if (b == crc_acc) begin
        fix.x = 6'(frame_buf[0] / 8'd10) + POS_OFFSET;
        fix.y = 6'(frame_buf[1] / 8'd10) + POS_OFFSET;
        fix.angle = 10'((18'(frame_buf[2]) * 18'(scale)) >> 8);
        fixes_due.push_back(fix);
      end
    end
  endtask

  always @(posedge clk) begin
    peer_fix_t want;
    if (rst) begin
      phase = PH_HUNT;
      crc_acc = CRC_INIT;
      scale = ANGLE_SCALE_RESET;
      fixes_due.delete();
    end else begin
      // Results leave before the byte of this edge is taken, so the oldest goes first.
      if (peer.valid && peer.ready) begin
        fixes_seen++;
        if (fixes_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", 0, 1);
        end else begin
          want = fixes_due.pop_front();
          if (peer.peer_x !== want.x) report_mismatch("peer_x", want.x, peer.peer_x);
          if (peer.peer_y !== want.y) report_mismatch("peer_y", want.y, peer.peer_y);
          if (peer.peer_angle !== want.angle) begin
            report_mismatch("peer_angle", want.angle, peer.peer_angle);
          end
        end
      end
      if (rx.valid && rx.ready) take_byte(rx.rx_byte);
      if (cfg_wr_en) scale = cfg_wr_data;
    end
    outstanding = fixes_due.size();
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the receiver testbench: clock, reset, byte stimulus, result stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crc8fpr_pkg::*;
  import crc8fpr_tb_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [SCALE_W-1:0] cfg_wr_data = '0;

  crc8fpr_rx_if   rx_ch ();
  crc8fpr_peer_if peer_ch ();

  int errors;
  int outstanding;
  int fixes_seen;
  int bytes_sent = 0;
  int frames_sent = 0;
  int scales_set = 0;
  int idle_cycles = 0;
  bit src_quiet = 1'b0;
  bit snk_quiet = 1'b0;

  always #5 clk = ~clk;

  crc8_framed_packet_receiver_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_ch),
    .peer        (peer_ch)
  );

  crc8fpr_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_ch),
    .peer        (peer_ch),
    .errors      (errors),
    .outstanding (outstanding),
    .fixes_seen  (fixes_seen)
  );

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // Payload bytes lean towards the extremes now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] frame_crc(input logic [7:0] pl [DATA_BYTES]);
    logic [7:0] acc;
    acc = CRC_INIT;
    foreach (pl[i]) acc = crc8_next(acc, pl[i]);
    return acc;
  endfunction

  // Called and left at a falling edge; valid stays high when the next item follows at once.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] pl [DATA_BYTES], input logic [7:0] flip);
    send_byte(START_BYTE);
    foreach (pl[i]) send_byte(pl[i]);
    send_byte(frame_crc(pl) ^ flip);
    frames_sent++;
  endtask

  // The scale is only changed once the receiver has gone quiet.
  task automatic set_scale(input logic [SCALE_W-1:0] v);
    rx_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    scales_set++;
  endtask

  // Result side: a fresh stall is drawn for every item taken.
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = draw_gap(snk_quiet);
      if (gap > 0) begin
        peer_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      peer_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(peer_ch.valid && peer_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (peer_ch.valid && peer_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= 2000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]         pl [DATA_BYTES];
    logic [SCALE_W-1:0] next_scale;
    int                 phase_bytes;
    int                 start_count;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    peer_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames at the reset scale.
    send_byte(8'h7F);
    foreach (pl[i]) pl[i] = 8'h00;
    send_frame(pl, 8'h00);
    foreach (pl[i]) pl[i] = 8'hFF;
    send_frame(pl, 8'h00);
    pl[0] = 8'd9;
    pl[1] = 8'd10;
    pl[2] = 8'd128;
    send_frame(pl, 8'h01);
    // Find a payload whose CRC equals the start value, so the check byte is 255.
    pl[0] = 8'h12;
    pl[1] = 8'h34;
    for (int v = 0; v < 256; v++) begin
      pl[2] = 8'(v);
      if (frame_crc(pl) == START_BYTE) break;
    end
    send_frame(pl, 8'h00);
    // A 255 that is a wrong check byte must still end the frame.
    pl[2] = pl[2] ^ 8'h01;
    send_frame(pl, frame_crc(pl) ^ START_BYTE);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: next_scale = '0;
        1: next_scale = '1;
        2: next_scale = SCALE_W'(1);
        3: next_scale = ANGLE_SCALE_RESET;
        default: next_scale = SCALE_W'($urandom);
      endcase
      set_scale(next_scale);
      start_count = bytes_sent;
      phase_bytes = 0;
      while (phase_bytes < 120) begin
        src_quiet = ($urandom_range(0, 3) == 0);
        snk_quiet = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 19))
          0, 1: begin
            send_byte(pick_byte());
            start_count++;
          end
          2: begin
            // Broken frame: the bytes that follow get swallowed as its payload.
            send_byte(START_BYTE);
            repeat ($urandom_range(0, DATA_BYTES - 1)) send_byte(pick_byte());
          end
          3, 4, 5: begin
            foreach (pl[i]) pl[i] = pick_byte();
            send_frame(pl, 8'($urandom_range(1, 255)));
          end
          default: begin
            foreach (pl[i]) pl[i] = pick_byte();
            send_frame(pl, 8'h00);
          end
        endcase
        phase_bytes = bytes_sent - start_count;
      end
    end

    rx_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Sent %0d bytes with %0d full frames; %0d peer results were compared.",
             bytes_sent, frames_sent, fixes_seen);
    $display("Angle scale was written %0d times, from 0 up to 1023.", scales_set);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
